/* design/smm_pkg.sv */
`default_nettype none

package smm_pkg;

  // Field and datapath widths.
  localparam int VAL_W  = 16;  // Q8.8 element and scale
  localparam int DIM_W  = 4;   // dimension registers
  localparam int IDX_W  = 3;   // row, column and inner index
  localparam int ACC_W  = 35;  // exact sum of up to eight 32-bit products
  localparam int PROD_W = ACC_W + VAL_W;
  localparam int RES_W  = 32;  // Q16.16 result
  localparam int FRAC_W = 8;   // fraction bits dropped after scaling

  // Input action codes.
  localparam logic [1:0] ACT_LOAD_X = 2'd0;
  localparam logic [1:0] ACT_LOAD_Y = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROWS_X    = 2'd0;
  localparam logic [1:0] REG_INNER_LEN = 2'd1;
  localparam logic [1:0] REG_COLS_Y    = 2'd2;
  localparam logic [1:0] REG_SCALE     = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLR,
    OP_MUL,
    OP_ACC,
    OP_SCALE
  } alu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_SCALE,
    ST_SAT
  } seq_state_t;

  typedef struct packed {
    alu_op_t          op;
    logic             out_load;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic             last;
  } seq_ctl_t;

endpackage

`default_nettype wire

/* design/scaled_matrix_multiply_top.sv */
`default_nettype none

// Scaled matrix multiply, Z = scale * X * Y, in Q8.8 fixed point with a
// saturated Q16.16 result. Load items (action 0 for X, 1 for Y) write one
// element each; loads with a row or column at or beyond MAX_DIM
// are dropped, as is action 3. A start item (action 2) produces one result
// item per element of Z in row-major order, with last high on the final
// one; nothing is produced when rows_x or cols_y is zero, and a zero
// inner_len gives all-zero sums. Dimension registers above MAX_DIM behave as
// MAX_DIM. Each element of Z is built on a single shared multiplier: every
// inner step runs store read, multiply and accumulate, then scale and
// saturate finish the element. After the cycle in which a start with a
// non-empty Z is taken, the input side stays closed until the final element
// is loaded into the result register, including every cycle that a finished
// element waits for that register to empty. The input side is not ready
// while a start is in progress, but the last result item may still be
// waiting at the output when the next item is taken. Configuration must be
// written only while the block is idle; the block itself does not enforce
// this, as cfg_ready is always high. X and Y entries read by a start must
// have been loaded beforehand, since the stores are not cleared by reset.

module scaled_matrix_multiply_top #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input items
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        action,
  input  wire logic [smm_pkg::IDX_W-1:0]         row,
  input  wire logic [smm_pkg::IDX_W-1:0]         col,
  input  wire logic signed [smm_pkg::VAL_W-1:0]  value,
  // Result items
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [smm_pkg::IDX_W-1:0]              out_row,
  output logic [smm_pkg::IDX_W-1:0]              out_col,
  output logic signed [smm_pkg::RES_W-1:0]       result,
  output logic                                   last,
  // Configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [smm_pkg::VAL_W-1:0]         cfg_data
);
  import smm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DIM_W-1:0]        rows_x, inner_len, cols_y;
  logic signed [VAL_W-1:0] scale;
  logic [DIM_W-1:0]        m, n, p;
  logic                    in_acc, cfg_acc, start, in_range;
  logic                    we_x, we_y, busy, out_free;
  logic [AW-1:0]           waddr, x_raddr, y_raddr;
  logic signed [VAL_W-1:0] x_data, y_data;
  logic signed [RES_W-1:0] alu_result;
  seq_ctl_t                ctl;

  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_ready  = !busy;
  assign start     = in_acc && (action == ACT_START);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_x    <= DIM_W'(8);
      inner_len <= DIM_W'(8);
      cols_y    <= DIM_W'(8);
      scale     <= VAL_W'(256);
    end else if (cfg_acc) begin
      unique case (cfg_index)
        REG_ROWS_X:    rows_x    <= cfg_data[DIM_W-1:0];
        REG_INNER_LEN: inner_len <= cfg_data[DIM_W-1:0];
        REG_COLS_Y:    cols_y    <= cfg_data[DIM_W-1:0];
        REG_SCALE:     scale     <= $signed(cfg_data);
        default:       ;
      endcase
    end
  end

  // Dimensions beyond the store size act as the store size.
  assign m = (rows_x    > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rows_x;
  assign n = (inner_len > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : inner_len;
  assign p = (cols_y    > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cols_y;

  // Element stores, addressed row * MAX_DIM + column.
  assign in_range = ({1'b0, row} < DIM_W'(MAX_DIM)) && ({1'b0, col} < DIM_W'(MAX_DIM));
  assign we_x     = in_acc && (action == ACT_LOAD_X) && in_range;
  assign we_y     = in_acc && (action == ACT_LOAD_Y) && in_range;
  assign waddr    = AW'(row * MAX_DIM + col);
  assign x_raddr  = AW'(ctl.i * MAX_DIM + ctl.k);
  assign y_raddr  = AW'(ctl.k * MAX_DIM + ctl.j);

  smm_store #(.DEPTH(DEPTH), .AW(AW)) u_x_store (
    .clk   (clk),
    .we    (we_x),
    .waddr (waddr),
    .wdata (value),
    .raddr (x_raddr),
    .rdata (x_data)
  );

  smm_store #(.DEPTH(DEPTH), .AW(AW)) u_y_store (
    .clk   (clk),
    .we    (we_y),
    .waddr (waddr),
    .wdata (value),
    .raddr (y_raddr),
    .rdata (y_data)
  );

  smm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .m        (m),
    .n        (n),
    .p        (p),
    .out_free (out_free),
    .busy     (busy),
    .ctl      (ctl)
  );

  smm_alu u_alu (
    .clk    (clk),
    .op     (ctl.op),
    .x_data (x_data),
    .y_data (y_data),
    .scale  (scale),
    .result (alu_result)
  );

  // Result register: the sequencer only loads it once the previous item has
  // gone or is leaving in the same cycle.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_row <= ctl.i;
      out_col <= ctl.j;
      result  <= alu_result;
      last    <= ctl.last;
    end
  end

  // A start with a non-empty result holds off further input items.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && m != DIM_W'(0) && p != DIM_W'(0) |=> !in_ready)
    else $error("start with results did not make the block busy");

  // The sequencer never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> out_free)
    else $error("result register loaded while still occupied");

  // After the final element of a run the input side opens again.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load && ctl.last |=> in_ready && out_valid && last)
    else $error("final result did not end the run");

endmodule

`default_nettype wire

/* design/smm_store.sv */
`default_nettype none

module smm_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic signed [smm_pkg::VAL_W-1:0] wdata,
  input  wire logic [AW-1:0]               raddr,
  output logic signed [smm_pkg::VAL_W-1:0] rdata
);
  import smm_pkg::*;

  logic signed [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/smm_alu.sv */
`default_nettype none

module smm_alu (
  input  wire logic                              clk,
  input  wire smm_pkg::alu_op_t                  op,
  input  wire logic signed [smm_pkg::VAL_W-1:0]  x_data,
  input  wire logic signed [smm_pkg::VAL_W-1:0]  y_data,
  input  wire logic signed [smm_pkg::VAL_W-1:0]  scale,
  output logic signed [smm_pkg::RES_W-1:0]       result
);
  import smm_pkg::*;

  localparam int HI_LSB = RES_W + FRAC_W - 1;

  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  mul_a;
  logic signed [VAL_W-1:0]  mul_b;
  logic [PROD_W-1:HI_LSB]   hi;
  logic                     ovf;

  // One multiplier serves both the element products and the final scaling.
  always_comb begin
    if (op == OP_SCALE) begin
      mul_a = acc;
      mul_b = scale;
    end else begin
      mul_a = ACC_W'(x_data);
      mul_b = y_data;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_MUL, OP_SCALE: prod <= mul_a * mul_b;
      OP_ACC:           acc  <= acc + $signed(prod[ACC_W-1:0]);
      OP_CLR:           acc  <= '0;
      default:          ;
    endcase
  end

  // Dropping the low fraction bits floors; anything beyond 32 bits saturates.
  assign hi  = prod[PROD_W-1:HI_LSB];
  assign ovf = !((&hi) || !(|hi));

  always_comb begin
    if (ovf) begin
      result = prod[PROD_W-1] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    end else begin
      result = prod[RES_W+FRAC_W-1:FRAC_W];
    end
  end

endmodule

`default_nettype wire

/* design/smm_ctrl.sv */
`default_nettype none

module smm_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [smm_pkg::DIM_W-1:0] m,
  input  wire logic [smm_pkg::DIM_W-1:0] n,
  input  wire logic [smm_pkg::DIM_W-1:0] p,
  input  wire logic                      out_free,
  output logic                           busy,
  output smm_pkg::seq_ctl_t              ctl
);
  import smm_pkg::*;

  seq_state_t       state, state_next;
  logic [IDX_W-1:0] i, i_next;
  logic [IDX_W-1:0] j, j_next;
  logic [IDX_W-1:0] k, k_next;
  logic             row_end, col_end, k_end;

  assign row_end = ({1'b0, i} + DIM_W'(1)) == m;
  assign col_end = ({1'b0, j} + DIM_W'(1)) == p;
  assign k_end   = ({1'b0, k} + DIM_W'(1)) == n;
  assign busy    = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next   = state;
    i_next       = i;
    j_next       = j;
    k_next       = k;
    ctl.op       = OP_NONE;
    ctl.out_load = 1'b0;
    ctl.i        = i;
    ctl.j        = j;
    ctl.k        = k;
    ctl.last     = row_end && col_end;
    unique case (state)
      ST_IDLE: begin
        if (start && m != DIM_W'(0) && p != DIM_W'(0)) begin
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
          ctl.op     = OP_CLR;
          state_next = (n == DIM_W'(0)) ? ST_SCALE : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        ctl.op     = OP_MUL;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        ctl.op = OP_ACC;
        if (k_end) begin
          k_next     = '0;
          state_next = ST_SCALE;
        end else begin
          k_next     = k + IDX_W'(1);
          state_next = ST_READ;
        end
      end
      ST_SCALE: begin
        ctl.op     = OP_SCALE;
        state_next = ST_SAT;
      end
      ST_SAT: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          ctl.op       = OP_CLR;
          k_next       = '0;
          if (row_end && col_end) begin
            state_next = ST_IDLE;
          end else begin
            if (col_end) begin
              j_next = '0;
              i_next = i + IDX_W'(1);
            end else begin
              j_next = j + IDX_W'(1);
            end
            state_next = (n == DIM_W'(0)) ? ST_SCALE : ST_READ;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire
